/* design/stc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants and types for the scalar-to-RGB colormap pipeline.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int V_WIDTH       = 18;
    localparam int STOP_BITS     = 16;
    localparam int PIX_WIDTH     = 8;
    localparam int NUM_CHAN      = 3;

    // Channel order: red, green, blue (index 0..2), Q0.16
    localparam logic [NUM_CHAN-1:0][STOP_BITS-1:0] STOP_DARK =
        {16'd7864, 16'd2621, 16'd1311};
    localparam logic [NUM_CHAN-1:0][STOP_BITS-1:0] STOP_MID =
        {16'd42598, 16'd36045, 16'd3277};
    localparam logic [NUM_CHAN-1:0][STOP_BITS-1:0] STOP_BRIGHT =
        {16'd13107, 16'd60293, 16'd64225};

    // Stage loads handed to the per-channel blend
    typedef struct packed {
        logic ld_mul;
        logic ld_out;
    } stc_ctl_t;

endpackage

/* design/stc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_in_if
// Sample request channel: one signed concentration sample per request.
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [17:0]       v_level;

    modport source (output valid, output v_level, input ready);
    modport sink   (input valid, input v_level, output ready);
endinterface

/* design/stc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_out_if
// Pixel request channel: one RGB pixel per request.
// ----------------------------------------------------------------------------
interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* design/stc_chan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_chan
// One color channel: linear blend of two stops by weight s, then scale to
// a byte. Two register stages (products, then byte).
// ----------------------------------------------------------------------------
module stc_chan #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS_DEF,
    parameter int CHAN      = 0
) (
    input  logic                         clk,
    input  stc_pkg::stc_ctl_t            ctl,
    input  logic                         upper,
    input  logic [FRAC_BITS:0]           s,
    output logic [stc_pkg::PIX_WIDTH-1:0] pix
);
    import stc_pkg::*;

    localparam int TW = FRAC_BITS + 1;
    localparam int PW = STOP_BITS + TW;
    localparam logic [TW-1:0] ONE_T = {1'b1, {FRAC_BITS{1'b0}}};

    logic [STOP_BITS-1:0]     stop_a;
    logic [STOP_BITS-1:0]     stop_b;
    logic [TW-1:0]            s_inv;
    logic [PW-1:0]            pa_next, pb_next;
    logic [PW-1:0]            pa_reg, pb_reg;
    logic [PW:0]              sum;
    logic [STOP_BITS-1:0]     c16;
    logic [STOP_BITS+PIX_WIDTH-1:0] scaled;
    logic [PIX_WIDTH-1:0]     pix_next;
    logic [PIX_WIDTH-1:0]     pix_reg;

    always_comb
    begin
        stop_a  = upper ? STOP_MID[CHAN]    : STOP_DARK[CHAN];
        stop_b  = upper ? STOP_BRIGHT[CHAN] : STOP_MID[CHAN];
        s_inv   = ONE_T - s;
        pa_next = PW'(stop_a) * PW'(s_inv);
        pb_next = PW'(stop_b) * PW'(s);
    end

    // c*255 as c*256 - c; the top byte never exceeds 254
    always_comb
    begin
        sum      = {1'b0, pa_reg} + {1'b0, pb_reg};
        c16      = sum[FRAC_BITS+STOP_BITS-1:FRAC_BITS];
        scaled   = {c16, {PIX_WIDTH{1'b0}}} - {{PIX_WIDTH{1'b0}}, c16};
        pix_next = scaled[STOP_BITS+PIX_WIDTH-1:STOP_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_mul)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (ctl.ld_out)
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

/* design/scalar_to_rgb_colormap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_to_rgb_colormap_core
// Three-stop smoothstep colormap: signed fixed-point sample to RGB pixel.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | handshake
//  --------+-----+-------------------------+-------------
//  sample  | in  | v_level (s18, Q.FRAC)   | valid/ready
//  pixel   | out | red, green, blue (u8)   | valid/ready
//
//  Five register stages: clamp/fold, square, smoothstep weight, channel
//  products, byte scale. One request per clock while pixel does not stall.
//  Reset clears the stage valid bits only; the pipeline is then empty.
//  A stall on pixel holds the last full stage; bubbles ahead of it still
//  collapse, so sample keeps being taken until every stage is full.
// ----------------------------------------------------------------------------
module scalar_to_rgb_colormap_core #(
    parameter int FRAC_BITS = stc_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    stc_in_if.sink     sample,
    stc_out_if.source  pixel
);
    import stc_pkg::*;

    localparam int NUM_STAGES = 5;
    localparam int TW = FRAC_BITS + 1;
    localparam int DW = (FRAC_BITS + 2 > V_WIDTH + 1) ? FRAC_BITS + 2 : V_WIDTH + 1;
    localparam logic [TW-1:0]        ONE_T     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [DW-1:0] ONE_D     = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [TW:0]          THREE_ONE = {2'b11, {FRAC_BITS{1'b0}}};

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;
    stc_ctl_t              ctl;

    // stage 1: t = clamp(2v), fold into u
    logic signed [DW-1:0] d_ext;
    logic [TW-1:0]        t;
    logic                 half;
    logic [TW:0]          t2;
    logic [TW:0]          u_wide;
    logic [TW-1:0]        u_reg;
    logic                 upper1_reg;

    // stage 2: q = u*u >> F, w = 3 - 2u
    logic [2*TW-1:0]      sq;
    logic [TW-1:0]        q_reg;
    logic [TW:0]          w_reg;
    logic                 upper2_reg;

    // stage 3: s = q*w >> F
    logic [2*TW:0]        prod;
    logic [TW+1:0]        s_raw;
    logic [TW-1:0]        s_next;
    logic [TW-1:0]        s_reg;
    logic                 upper3_reg;

    logic [PIX_WIDTH-1:0] pix [NUM_CHAN];

    // ready chain: a stage loads when empty or when the next one moves
    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || pixel.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign sample.ready = rdy[0];
    assign ctl.ld_mul   = rdy[3];
    assign ctl.ld_out   = rdy[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= sample.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        d_ext = DW'(signed'({sample.v_level, 1'b0}));
        if (d_ext < 0)
        begin
            t = '0;
        end
        else if (d_ext > ONE_D)
        begin
            t = ONE_T;
        end
        else
        begin
            t = d_ext[TW-1:0];
        end
        half   = t[FRAC_BITS] | t[FRAC_BITS-1];
        t2     = {t, 1'b0};
        u_wide = half ? t2 - {1'b0, ONE_T} : t2;
    end

    always_comb
    begin
        sq    = (2*TW)'(u_reg) * (2*TW)'(u_reg);
        prod  = (2*TW+1)'(q_reg) * (2*TW+1)'(w_reg);
        s_raw = prod[2*TW:FRAC_BITS];
        s_next = (s_raw > {2'b00, ONE_T}) ? ONE_T : s_raw[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            u_reg      <= u_wide[TW-1:0];
            upper1_reg <= half;
        end
        if (rdy[1])
        begin
            q_reg      <= sq[FRAC_BITS+TW-1:FRAC_BITS];
            w_reg      <= THREE_ONE - {u_reg, 1'b0};
            upper2_reg <= upper1_reg;
        end
        if (rdy[2])
        begin
            s_reg      <= s_next;
            upper3_reg <= upper2_reg;
        end
    end

    // stages 4 and 5, one blend per channel
    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_chan
        stc_chan #(
            .FRAC_BITS (FRAC_BITS),
            .CHAN      (ch)
        ) u_chan (
            .clk   (clk),
            .ctl   (ctl),
            .upper (upper3_reg),
            .s     (s_reg),
            .pix   (pix[ch])
        );
    end

    assign pixel.valid = vld_reg[NUM_STAGES-1];
    assign pixel.red   = pix[0];
    assign pixel.green = pix[1];
    assign pixel.blue  = pix[2];

endmodule
